[design/vtmix_pkg.sv]
package vtmix_pkg;

  // Fixed-point format: ONE stands for 1.0
  localparam int FRAC_BITS = 14;
  localparam int ONE_I     = 1 << FRAC_BITS;
  localparam int UW        = FRAC_BITS + 1;     // unit value 0..ONE
  localparam int AXW       = 16;                // signed axis width
  localparam int PULSEW    = 12;
  localparam int STEPW     = 11;
  localparam int IDXW      = 3;
  localparam int CFG_W     = UW;
  localparam int MPW       = AXW + UW + 1;      // motor product width
  localparam int APW       = AXW + UW;          // aft product width
  localparam int AFW       = APW + 1;           // aft rounding width
  localparam int XW        = AXW + 2;           // extended axis width

  localparam logic [UW-1:0] ONE  = UW'(ONE_I);
  localparam logic [UW-1:0] HALF = UW'(ONE_I / 2);

  // Stream widths
  localparam int IN_BITS  = PULSEW + 4 * AXW;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = 2 + 9 * UW;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // Pulse thresholds in microseconds
  localparam logic [PULSEW-1:0] PULSE_VERT_MAX = PULSEW'(1350);
  localparam logic [PULSEW-1:0] PULSE_MID_MAX  = PULSEW'(1650);

  // Flight modes
  localparam logic [1:0] MODE_VERT  = 2'd0;
  localparam logic [1:0] MODE_MID   = 2'd1;
  localparam logic [1:0] MODE_HORIZ = 2'd2;
  localparam logic [1:0] MODE_UNSET = 2'd3;

  // Register indexes
  localparam logic [IDXW-1:0] CFG_ROLL_GAIN  = 3'd0;
  localparam logic [IDXW-1:0] CFG_YAW_GAIN   = 3'd1;
  localparam logic [IDXW-1:0] CFG_TRANS_STEP = 3'd2;
  localparam logic [IDXW-1:0] CFG_MID_TARGET = 3'd3;
  localparam logic [IDXW-1:0] CFG_AFT_DZ     = 3'd4;
  localparam logic [IDXW-1:0] CFG_AFT_GAIN   = 3'd5;

  // Register reset values
  localparam logic [UW-1:0]    RST_ROLL_GAIN  = UW'(2458);
  localparam logic [UW-1:0]    RST_YAW_GAIN   = UW'(2458);
  localparam logic [STEPW-1:0] RST_TRANS_STEP = STEPW'(164);
  localparam logic [UW-1:0]    RST_MID_TARGET = UW'(13107);
  localparam logic [UW-1:0]    RST_AFT_DZ     = UW'(164);
  localparam logic [UW-1:0]    RST_AFT_GAIN   = UW'(6620);

  typedef struct packed {
    logic [UW-1:0]    roll_gain;
    logic [UW-1:0]    yaw_gain;
    logic [STEPW-1:0] trans_step;
    logic [UW-1:0]    mid_target;
    logic [UW-1:0]    aft_dz;
    logic [UW-1:0]    aft_gain;
  } cfg_t;

  typedef struct packed {
    logic [PULSEW-1:0]     pulse;
    logic signed [AXW-1:0] roll;
    logic signed [AXW-1:0] pitch;
    logic signed [AXW-1:0] yaw;
    logic signed [AXW-1:0] thr;
  } item_t;

  // Product stage contents
  typedef struct packed {
    logic [1:0]            mode;
    logic signed [MPW-1:0] motor_prod;
    logic signed [XW-1:0]  thr_base;
    logic                  aft_neg;
    logic                  aft_pos;
    logic [APW-1:0]        aft_prod;
    logic [UW-1:0]         tilt;
    logic [UW-1:0]         elevator;
    logic [UW-1:0]         rudder;
  } prod_t;

  // v/2 with v clamped to 0..2*ONE, rounded half up
  function automatic logic [UW-1:0] half_unit(input logic signed [XW-1:0] v);
    logic [UW:0]   c;
    logic [UW+1:0] s;
    if (v < 0) begin
      c = '0;
    end else if (v > XW'(2 * ONE_I)) begin
      c = (UW+1)'(2 * ONE_I);
    end else begin
      c = v[UW:0];
    end
    s = {1'b0, c} + (UW+2)'(1);
    return s[UW:1];
  endfunction

  // num / ONE rounded half up, clamped to 0..ONE
  function automatic logic [UW-1:0] mix_round(input logic signed [MPW+1:0] num);
    logic signed [MPW+1:0] m;
    logic signed [MPW+1:0] r;
    m = num + (MPW+2)'(ONE_I / 2);
    r = m >>> FRAC_BITS;
    if (r < 0) begin
      return '0;
    end else if (r > (MPW+2)'(ONE_I)) begin
      return ONE;
    end else begin
      return r[UW-1:0];
    end
  endfunction

endpackage

[design/vtmix_duty.sv]
module vtmix_duty (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic [1:0]             mode_new,
  input  vtmix_pkg::cfg_t        cfg,
  output logic [vtmix_pkg::UW-1:0] duty_next
);

  logic [1:0]               mode_reg;
  logic [vtmix_pkg::UW-1:0] target_duty;
  logic [vtmix_pkg::UW-1:0] current_duty;
  logic [vtmix_pkg::UW-1:0] target_next;
  logic signed [vtmix_pkg::UW+1:0] cur_s;
  logic signed [vtmix_pkg::UW+1:0] step_s;
  logic signed [vtmix_pkg::UW+1:0] slew;

  // Reload the target on a mode change
  always_comb begin
    if (mode_new != mode_reg) begin
      case (mode_new)
        vtmix_pkg::MODE_VERT: target_next = vtmix_pkg::ONE;
        vtmix_pkg::MODE_MID:  target_next = cfg.mid_target;
        default:              target_next = '0;
      endcase
    end else begin
      target_next = target_duty;
    end
  end

  // Slew one step toward the target, step down when equal, clamp to 0..ONE
  always_comb begin
    cur_s  = $signed({2'b00, current_duty});
    step_s = $signed((vtmix_pkg::UW+2)'(cfg.trans_step));
    if (target_next > current_duty) begin
      slew = cur_s + step_s;
    end else begin
      slew = cur_s - step_s;
    end
    if (slew < 0) begin
      duty_next = '0;
    end else if (slew > (vtmix_pkg::UW+2)'(vtmix_pkg::ONE_I)) begin
      duty_next = vtmix_pkg::ONE;
    end else begin
      duty_next = slew[vtmix_pkg::UW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg     <= vtmix_pkg::MODE_UNSET;
      target_duty  <= vtmix_pkg::ONE;
      current_duty <= vtmix_pkg::HALF;
    end else if (en) begin
      mode_reg     <= mode_new;
      target_duty  <= target_next;
      current_duty <= duty_next;
    end
  end

endmodule

[design/vtmix_front.sv]
module vtmix_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [vtmix_pkg::IN_W-1:0] s_tdata,
  input  vtmix_pkg::cfg_t            cfg,
  input  logic                       adv,
  output logic                       prod_valid,
  output vtmix_pkg::prod_t           prod
);

  logic             in_valid;
  vtmix_pkg::item_t item;
  vtmix_pkg::prod_t prod_next;
  logic             ready2;

  logic [1:0]                        nm;
  logic                              horiz;
  logic [vtmix_pkg::UW-1:0]          gain;
  logic signed [vtmix_pkg::AXW-1:0]  ax;
  logic signed [vtmix_pkg::XW-1:0]   roll_x;
  logic signed [vtmix_pkg::XW-1:0]   pitch_x;
  logic signed [vtmix_pkg::XW-1:0]   yaw_x;
  logic signed [vtmix_pkg::XW-1:0]   thr_x;
  logic signed [vtmix_pkg::XW-1:0]   one_x;
  logic signed [vtmix_pkg::XW-1:0]   dz_x;
  logic signed [vtmix_pkg::XW-1:0]   dz_sum;
  logic signed [vtmix_pkg::XW-1:0]   dz_diff;
  logic signed [vtmix_pkg::XW-1:0]   dz_dist;
  logic [vtmix_pkg::AXW-1:0]         aft_span;
  logic signed [vtmix_pkg::MPW-1:0]  gain_w;
  logic signed [vtmix_pkg::MPW-1:0]  ax_w;

  // Each stage loads when empty or when its content moves on
  assign ready2   = !prod_valid || adv;
  assign s_tready = !in_valid || ready2;

  always_comb begin
    // Mode from the pulse
    if (item.pulse < vtmix_pkg::PULSE_VERT_MAX) begin
      nm = vtmix_pkg::MODE_VERT;
    end else if (item.pulse < vtmix_pkg::PULSE_MID_MAX) begin
      nm = vtmix_pkg::MODE_MID;
    end else begin
      nm = vtmix_pkg::MODE_HORIZ;
    end
    horiz = (nm == vtmix_pkg::MODE_HORIZ);

    roll_x  = vtmix_pkg::XW'(item.roll);
    pitch_x = vtmix_pkg::XW'(item.pitch);
    yaw_x   = vtmix_pkg::XW'(item.yaw);
    thr_x   = vtmix_pkg::XW'(item.thr);
    one_x   = vtmix_pkg::XW'(vtmix_pkg::ONE_I);
    dz_x    = $signed({3'b000, cfg.aft_dz});

    // Wing motor differential: yaw when horizontal, roll otherwise
    gain   = horiz ? cfg.yaw_gain : cfg.roll_gain;
    ax     = horiz ? item.yaw : item.roll;
    gain_w = $signed({{(vtmix_pkg::MPW-vtmix_pkg::UW){1'b0}}, gain});
    ax_w   = vtmix_pkg::MPW'(ax);

    // Aft motor deadzone split
    dz_sum   = pitch_x + dz_x;
    dz_diff  = pitch_x - dz_x;
    dz_dist  = (dz_sum <= 0) ? -dz_sum : dz_diff;
    aft_span = dz_dist[vtmix_pkg::AXW-1:0];

    prod_next.mode       = nm;
    prod_next.motor_prod = gain_w * ax_w;
    prod_next.thr_base   = thr_x + one_x;
    prod_next.aft_neg    = (dz_sum <= 0);
    prod_next.aft_pos    = (dz_sum > 0) && (dz_diff >= 0);
    prod_next.aft_prod   = {{vtmix_pkg::AXW{1'b0}}, cfg.aft_gain}
                         * {{vtmix_pkg::UW{1'b0}}, aft_span};
    prod_next.tilt       = horiz ? vtmix_pkg::half_unit(one_x - roll_x)
                                 : vtmix_pkg::half_unit(yaw_x + one_x);
    prod_next.elevator   = vtmix_pkg::half_unit(one_x - pitch_x);
    prod_next.rudder     = vtmix_pkg::half_unit(yaw_x + one_x);
  end

  // Control: input and product stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      prod_valid <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (ready2) begin
        prod_valid <= in_valid;
      end
    end
  end

  // Payload: capture the transfer, then the products
  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item.pulse <= s_tdata[11:0];
      item.roll  <= $signed(s_tdata[27:12]);
      item.pitch <= $signed(s_tdata[43:28]);
      item.yaw   <= $signed(s_tdata[59:44]);
      item.thr   <= $signed(s_tdata[75:60]);
    end
    if (ready2 && in_valid) begin
      prod <= prod_next;
    end
  end

endmodule

[design/vtol_transition_and_control_mixer.sv]
// VTOL transition and control mixer.
// Slave stream: one control frame per transfer (transition pulse and the
// roll, pitch, yaw and throttle axes, Q2.14). Master stream: one set of
// actuator values per frame, in the order the frames came in.
// Configuration: write cfg_data into register cfg_index while cfg_we is high;
// write only while no frame is in flight.
// Pipeline: input register, product register (mode decode and the two
// multipliers), result register (rounding, transition duty slew, holds).
// An accepted frame passes through these registers in order to the master
// side. One frame per cycle is sustained while m_tready stays high; the two
// multipliers sit side by side in the product stage and the result stage has none.
// Reset empties the pipeline, loads register defaults, sets the transition
// duty to 0.5, the mode to unset, aft motor to stop, elevator and rudder to
// center. When the receiver stalls, the result holds and the two earlier
// stages keep filling; s_tready drops once all three are full.
module vtol_transition_and_control_mixer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // trans_pulse, roll_axis, pitch_axis, yaw_axis, throttle_axis, zero pad
  input  logic [vtmix_pkg::IN_W-1:0]  s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // mode, left_motor, right_motor, aft_motor, left_tilt, right_tilt,
  // left_trans, right_trans, elevator, rudder, zero pad
  output logic [vtmix_pkg::OUT_W-1:0] m_tdata,
  input  logic                        cfg_we,
  input  logic [vtmix_pkg::IDXW-1:0]  cfg_index,
  input  logic [vtmix_pkg::CFG_W-1:0] cfg_data
);

  vtmix_pkg::cfg_t  cfg;
  vtmix_pkg::prod_t prod;
  logic             prod_valid;
  logic             adv;
  logic             en;
  logic             horiz;

  logic [vtmix_pkg::UW-1:0] duty_next;
  logic [vtmix_pkg::UW-1:0] aft_hold;
  logic [vtmix_pkg::UW-1:0] elevator_hold;
  logic [vtmix_pkg::UW-1:0] rudder_hold;
  logic [vtmix_pkg::UW-1:0] aft_hold_next;
  logic [vtmix_pkg::UW-1:0] elevator_hold_next;
  logic [vtmix_pkg::UW-1:0] rudder_hold_next;
  logic [vtmix_pkg::UW-1:0] aft_new;
  logic [vtmix_pkg::UW-1:0] left_motor;
  logic [vtmix_pkg::UW-1:0] right_motor;
  logic [vtmix_pkg::UW-1:0] left_trans;

  logic signed [vtmix_pkg::MPW+1:0] base_w;
  logic signed [vtmix_pkg::MPW+1:0] prod_w;
  logic [vtmix_pkg::AFW-1:0]        aft_rnd;
  logic [vtmix_pkg::AFW-1:0]        aft_q;
  logic [vtmix_pkg::AFW-1:0]        aft_sum;

  logic [vtmix_pkg::OUT_W-1:0] m_tdata_next;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.roll_gain  <= vtmix_pkg::RST_ROLL_GAIN;
      cfg.yaw_gain   <= vtmix_pkg::RST_YAW_GAIN;
      cfg.trans_step <= vtmix_pkg::RST_TRANS_STEP;
      cfg.mid_target <= vtmix_pkg::RST_MID_TARGET;
      cfg.aft_dz     <= vtmix_pkg::RST_AFT_DZ;
      cfg.aft_gain   <= vtmix_pkg::RST_AFT_GAIN;
    end else if (cfg_we) begin
      case (cfg_index)
        vtmix_pkg::CFG_ROLL_GAIN:  cfg.roll_gain  <= cfg_data;
        vtmix_pkg::CFG_YAW_GAIN:   cfg.yaw_gain   <= cfg_data;
        vtmix_pkg::CFG_TRANS_STEP: cfg.trans_step <= cfg_data[vtmix_pkg::STEPW-1:0];
        vtmix_pkg::CFG_MID_TARGET: cfg.mid_target <= cfg_data;
        vtmix_pkg::CFG_AFT_DZ:     cfg.aft_dz     <= cfg_data;
        vtmix_pkg::CFG_AFT_GAIN:   cfg.aft_gain   <= cfg_data;
        default: ;
      endcase
    end
  end

  vtmix_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .cfg        (cfg),
    .adv        (adv),
    .prod_valid (prod_valid),
    .prod       (prod)
  );

  // Result register loads when empty or being taken
  assign adv   = !m_tvalid || m_tready;
  assign en    = prod_valid && adv;
  assign horiz = (prod.mode == vtmix_pkg::MODE_HORIZ);

  vtmix_duty u_duty (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .mode_new  (prod.mode),
    .cfg       (cfg),
    .duty_next (duty_next)
  );

  always_comb begin
    // Wing motors: (thr+1)/2 plus and minus the differential product
    base_w      = (vtmix_pkg::MPW+2)'(prod.thr_base) <<< (vtmix_pkg::FRAC_BITS - 1);
    prod_w      = (vtmix_pkg::MPW+2)'(prod.motor_prod);
    left_motor  = vtmix_pkg::mix_round(base_w + prod_w);
    right_motor = vtmix_pkg::mix_round(base_w - prod_w);

    // Aft motor: rounded product below the deadzone, half plus it above, zero inside, clamped to ONE
    aft_rnd = {1'b0, prod.aft_prod} + vtmix_pkg::AFW'(vtmix_pkg::ONE_I / 2);
    aft_q   = aft_rnd >> vtmix_pkg::FRAC_BITS;
    aft_sum = prod.aft_pos ? aft_q + vtmix_pkg::AFW'(vtmix_pkg::ONE_I / 2) : aft_q;
    if (!prod.aft_neg && !prod.aft_pos) begin
      aft_new = '0;
    end else if (aft_sum > vtmix_pkg::AFW'(vtmix_pkg::ONE_I)) begin
      aft_new = vtmix_pkg::ONE;
    end else begin
      aft_new = aft_sum[vtmix_pkg::UW-1:0];
    end

    // Drive only what the mode owns, hold the rest
    aft_hold_next      = horiz ? aft_hold : aft_new;
    elevator_hold_next = horiz ? prod.elevator : elevator_hold;
    rudder_hold_next   = horiz ? prod.rudder : rudder_hold;

    left_trans = vtmix_pkg::ONE - duty_next;

    m_tdata_next = {
      {(vtmix_pkg::OUT_W - vtmix_pkg::OUT_BITS){1'b0}},
      rudder_hold_next,
      elevator_hold_next,
      duty_next,
      left_trans,
      prod.tilt,
      prod.tilt,
      aft_hold_next,
      right_motor,
      left_motor,
      prod.mode
    };
  end

  // Control: result valid and held actuator state
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid      <= 1'b0;
      aft_hold      <= '0;
      elevator_hold <= vtmix_pkg::HALF;
      rudder_hold   <= vtmix_pkg::HALF;
    end else begin
      if (adv) begin
        m_tvalid <= prod_valid;
      end
      if (en) begin
        aft_hold      <= aft_hold_next;
        elevator_hold <= elevator_hold_next;
        rudder_hold   <= rudder_hold_next;
      end
    end
  end

  // Payload: result register
  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= m_tdata_next;
    end
  end

endmodule

[tb/vtol_transition_and_control_mixer_test.sv]
module vtol_transition_and_control_mixer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import vtmix_pkg::*;

  localparam int IDLE_LIMIT    = 2000;
  localparam int DRAIN_CYCLES  = 8;
  localparam int RANDOM_PHASES = 11;
  localparam int PHASE_FRAMES  = 50;
  localparam int NUM_FIELDS    = 10;

  // Indexes past the last register; writes there must be ignored
  localparam logic [IDXW-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [IDXW-1:0] CFG_SPARE_B = 3'd7;

  // Typical stick positions for the transition channel
  localparam logic [PULSEW-1:0] PULSE_LOW    = 12'd1000;
  localparam logic [PULSEW-1:0] PULSE_CENTER = 12'd1500;
  localparam logic [PULSEW-1:0] PULSE_HIGH   = 12'd2000;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [IN_W-1:0]      s_tdata   = '0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [OUT_W-1:0]     m_tdata;
  logic                 cfg_we    = 1'b0;
  logic [IDXW-1:0]      cfg_index = CFG_ROLL_GAIN;
  logic [CFG_W-1:0]     cfg_data  = '0;

  // Register shadow
  longint roll_gain_q, yaw_gain_q, step_q, mid_q, dz_q, aft_gain_q;
  // Mixer state as the block should hold it
  logic [1:0] mode_now;
  longint     target_now, duty_now, aft_now, elev_now, rudder_now;

  logic [OUT_W-1:0] pending_outputs[$];
  int               errors         = 0;
  int               stalled_cycles = 0;
  int               rx_hold        = 0;
  bit               no_idle        = 1'b0;

  string field_names [NUM_FIELDS] = '{"mode", "left_motor", "right_motor", "aft_motor",
    "left_tilt", "right_tilt", "left_trans", "right_trans", "elevator", "rudder"};

  vtol_transition_and_control_mixer u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic longint sat(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Divide by ONE, rounding half toward plus infinity
  function automatic longint round_q(longint num);
    return (num + longint'(ONE_I / 2)) >>> FRAC_BITS;
  endfunction

  function automatic longint halve_sat(longint v);
    return (sat(v, 0, 2 * ONE_I) + 1) >>> 1;
  endfunction

  function automatic longint thrust_mix(longint thr, longint gain, longint ax);
    return sat(round_q((thr + ONE_I) * (ONE_I / 2) + gain * ax), 0, ONE_I);
  endfunction

  function automatic void load_reset_state();
    roll_gain_q = RST_ROLL_GAIN;
    yaw_gain_q  = RST_YAW_GAIN;
    step_q      = RST_TRANS_STEP;
    mid_q       = RST_MID_TARGET;
    dz_q        = RST_AFT_DZ;
    aft_gain_q  = RST_AFT_GAIN;
    mode_now    = MODE_UNSET;
    target_now  = ONE_I;
    duty_now    = ONE_I / 2;
    aft_now     = 0;
    elev_now    = ONE_I / 2;
    rudder_now  = ONE_I / 2;
  endfunction

  // Advance the mixer state by one frame and return the packed actuator set
  function automatic logic [OUT_W-1:0] mix_frame(logic [PULSEW-1:0] pulse,
      logic signed [AXW-1:0] roll, logic signed [AXW-1:0] pitch,
      logic signed [AXW-1:0] yaw, logic signed [AXW-1:0] thr);
    longint     r, p, y, t, lm, rm, tilt;
    logic [1:0] nm;
    r = roll;
    p = pitch;
    y = yaw;
    t = thr;
    nm = (pulse < PULSE_VERT_MAX) ? MODE_VERT : ((pulse < PULSE_MID_MAX) ? MODE_MID : MODE_HORIZ);
    // Reload the duty target only on a change of mode
    if (nm != mode_now) begin
      mode_now = nm;
      case (nm)
        MODE_VERT: target_now = ONE_I;
        MODE_MID:  target_now = mid_q;
        default:   target_now = 0;
      endcase
    end
    if (target_now > duty_now) duty_now = duty_now + step_q;
    else duty_now = duty_now - step_q;
    duty_now = sat(duty_now, 0, ONE_I);

    if (mode_now == MODE_HORIZ) begin
      tilt       = halve_sat(ONE_I - r);
      elev_now   = halve_sat(ONE_I - p);
      lm         = thrust_mix(t, yaw_gain_q, y);
      rm         = thrust_mix(t, yaw_gain_q, -y);
      rudder_now = halve_sat(y + ONE_I);
    end else begin
      lm   = thrust_mix(t, roll_gain_q, r);
      rm   = thrust_mix(t, roll_gain_q, -r);
      tilt = halve_sat(y + ONE_I);
      // Reversible aft motor with a deadzone around center pitch
      if (p <= -dz_q) aft_now = sat(round_q(aft_gain_q * (-p - dz_q)), 0, ONE_I);
      else if (p >= dz_q) aft_now = sat(ONE_I / 2 + round_q(aft_gain_q * (p - dz_q)), 0, ONE_I);
      else aft_now = 0;
    end
    return OUT_W'({UW'(rudder_now), UW'(elev_now), UW'(duty_now), UW'(ONE_I - duty_now),
                   UW'(tilt), UW'(tilt), UW'(aft_now), UW'(rm), UW'(lm), mode_now});
  endfunction

  function automatic logic [UW-1:0] field_of(logic [OUT_W-1:0] w, int k);
    if (k == 0) return UW'(w[1:0]);
    return w[2 + UW * (k - 1) +: UW];
  endfunction

  function automatic int draw_wait();
    return no_idle ? 0 : int'($urandom_range(0, 5));
  endfunction

  function automatic logic signed [AXW-1:0] rand_axis();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return 16'sh8000;
          1: return 16'sh7FFF;
          2: return -16'sd16384;
          3: return 16'sd16384;
          default: return '0;
        endcase
      end
      1: return AXW'($urandom);
      default: return AXW'(int'($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic logic [PULSEW-1:0] rand_pulse(int cls);
    if ($urandom_range(0, 9) == 0) return PULSEW'($urandom_range(0, 4095));
    case (cls)
      0: return PULSEW'($urandom_range(0, 1349));
      1: return PULSEW'($urandom_range(1350, 1649));
      2: return PULSEW'($urandom_range(1650, 4095));
      default: begin
        if ($urandom_range(0, 1) == 0) return PULSEW'($urandom_range(1348, 1351));
        return PULSEW'($urandom_range(1648, 1651));
      end
    endcase
  endfunction

  function automatic int unsigned pick_reg(int style, int unsigned hi, int unsigned full);
    case (style)
      1: return 0;
      2: return hi;
      3: return full;
      default: begin
        case ($urandom_range(0, 7))
          0: return 0;
          1: return hi;
          2: return $urandom_range(0, full);
          default: return $urandom_range(0, hi);
        endcase
      end
    endcase
  endfunction

  // Check each result transfer against the oldest pending actuator set
  task automatic check_actuators(input logic [OUT_W-1:0] got);
    logic [OUT_W-1:0] want;
    if (pending_outputs.size() == 0) begin
      $error("result transfer with no frame pending: %h", got);
      errors++;
      return;
    end
    want = pending_outputs.pop_front();
    for (int k = 0; k < NUM_FIELDS; k++) begin
      if (field_of(got, k) !== field_of(want, k)) begin
        $error("%s: expected %0d, got %0d", field_names[k], field_of(want, k), field_of(got, k));
        errors++;
      end
    end
  endtask

  // Receiver: take results, dropping ready after each for a random wait from draw_wait
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_hold = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        check_actuators(m_tdata);
        rx_hold = draw_wait();
      end
      if (rx_hold > 0) begin
        m_tready <= 1'b0;
        rx_hold--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  task automatic send_frame(input logic [PULSEW-1:0] pulse, input logic signed [AXW-1:0] roll,
      input logic signed [AXW-1:0] pitch, input logic signed [AXW-1:0] yaw,
      input logic signed [AXW-1:0] thr);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_W'({thr, yaw, pitch, roll, pulse});
    do @(posedge clk); while (!s_tready);
    pending_outputs.push_back(mix_frame(pulse, roll, pitch, yaw, thr));
  endtask

  task automatic send_mode_frames(input logic [PULSEW-1:0] pulse, input int n);
    repeat (n) send_frame(pulse, rand_axis(), rand_axis(), rand_axis(), rand_axis());
  endtask

  // Drop valid and wait until every pending result has come back
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDXW-1:0] idx, input int unsigned val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(val);
    case (idx)
      CFG_ROLL_GAIN:  roll_gain_q = val % (1 << UW);
      CFG_YAW_GAIN:   yaw_gain_q  = val % (1 << UW);
      CFG_TRANS_STEP: step_q      = val % (1 << STEPW);
      CFG_MID_TARGET: mid_q       = val % (1 << UW);
      CFG_AFT_DZ:     dz_q        = val % (1 << UW);
      CFG_AFT_GAIN:   aft_gain_q  = val % (1 << UW);
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic randomize_regs(input int style);
    write_reg(CFG_ROLL_GAIN, pick_reg(style, ONE_I, (1 << UW) - 1));
    write_reg(CFG_YAW_GAIN, pick_reg(style, ONE_I, (1 << UW) - 1));
    write_reg(CFG_TRANS_STEP, pick_reg(style, 1638, (1 << STEPW) - 1));
    write_reg(CFG_MID_TARGET, pick_reg(style, ONE_I, (1 << UW) - 1));
    write_reg(CFG_AFT_DZ, pick_reg(style, ONE_I, (1 << UW) - 1));
    write_reg(CFG_AFT_GAIN, pick_reg(style, (1 << UW) - 1, (1 << UW) - 1));
    if ($urandom_range(0, 2) == 0) begin
      write_reg(($urandom_range(0, 1) == 0) ? CFG_SPARE_A : CFG_SPARE_B, $urandom);
    end
  endtask

  // First frame from the unset mode, pulse thresholds, axis extremes
  task automatic test_mode_decode();
    send_frame(PULSE_CENTER, '0, '0, '0, '0);
    send_frame(12'd1349, 16'sd16384, -16'sd16384, 16'sd16384, -16'sd16384);
    send_frame(12'd1350, -16'sd16384, 16'sd16384, -16'sd16384, 16'sd16384);
    send_frame(12'd1649, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000);
    send_frame(12'd1650, 16'sd16384, 16'sd16384, -16'sd16384, 16'sd16384);
    send_frame(12'd4095, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
    send_frame(12'd0, '0, '0, '0, '0);
    send_frame(12'd1650, -16'sd16384, -16'sd16384, 16'sd16384, -16'sd16384);
  endtask

  // Pitch on and around the deadzone edges, steep slope, zero deadzone
  task automatic test_aft_deadzone();
    settle();
    write_reg(CFG_AFT_DZ, 8192);
    write_reg(CFG_AFT_GAIN, (1 << UW) - 1);
    send_frame(PULSE_LOW, '0, 16'sd8192, '0, '0);
    send_frame(PULSE_LOW, '0, 16'sd8191, '0, '0);
    send_frame(PULSE_LOW, '0, -16'sd8191, '0, '0);
    send_frame(PULSE_LOW, '0, -16'sd8192, '0, '0);
    send_frame(PULSE_LOW, '0, -16'sd8193, '0, '0);
    send_frame(PULSE_CENTER, '0, 16'sh7FFF, '0, '0);
    send_frame(PULSE_CENTER, '0, 16'sh8000, '0, '0);
    settle();
    write_reg(CFG_AFT_DZ, 0);
    send_frame(PULSE_LOW, '0, '0, '0, '0);
  endtask

  // Duty slew to both clamps, step down at the target, mid target reload
  task automatic test_duty_slew();
    settle();
    write_reg(CFG_TRANS_STEP, (1 << STEPW) - 1);
    send_mode_frames(PULSE_LOW, 5);
    send_mode_frames(PULSE_HIGH, 9);
    send_mode_frames(PULSE_CENTER, 2);
    settle();
    // new mid target must wait for the next mode change
    write_reg(CFG_MID_TARGET, 4000);
    send_mode_frames(PULSE_CENTER, 2);
    send_mode_frames(PULSE_LOW, 1);
    send_mode_frames(PULSE_CENTER, 1);
    settle();
    write_reg(CFG_TRANS_STEP, 0);
    send_mode_frames(PULSE_CENTER, 1);
  endtask

  // Runs of frames per pulse class under changing register settings
  task automatic test_random_phases();
    int remaining, run_len, cls, style;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      style = (ph >= 1 && ph <= 3) ? ph : 0;
      randomize_regs(style);
      no_idle = (ph % 4 == 3);
      remaining = PHASE_FRAMES;
      while (remaining > 0) begin
        run_len = $urandom_range(1, 20);
        cls = $urandom_range(0, 3);
        for (int j = 0; j < run_len && remaining > 0; j++) begin
          send_frame(rand_pulse(cls), rand_axis(), rand_axis(), rand_axis(), rand_axis());
          remaining--;
        end
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    load_reset_state();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_mode_decode();
    test_aft_deadzone();
    test_duty_slew();
    test_random_phases();
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
